/* rtl/core/alen_pkg.sv */
// Package for the array list engine: shared constants, command and state codes,
// and the packed request and result types.
// No dependencies.
`timescale 1ns / 1ps

package alen_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int KEY_W     = 32;
  localparam int POS_W     = 8;
  localparam int COUNT_W   = 9;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } alen_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } alen_state_t;

  typedef struct packed {
    alen_cmd_t                cmd;
    logic [POS_W-1:0]         position;
    logic signed [KEY_W-1:0]  key;
  } alen_item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [KEY_W-1:0]  key_out;
    logic [COUNT_W-1:0]       count;
    logic                     empty_res;
  } alen_result_t;

endpackage

/* rtl/core/alen_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module alen_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/array_list_engine_unit.sv */
// Top level of the array list engine: command sequencer and the list store.
// Depends on alen_pkg and alen_ram.
`timescale 1ns / 1ps

// Channel   Signals                 Transfer
// --------  ----------------------  ---------------------------------------------
// request   start, busy, item       accepted at a rising edge with start high, busy low
// result    done, result            shown for one cycle while done is high
//
// Append, a search of an empty list, and a read or remove whose position is not below
// the count are answered straight from the idle state. Read, remove and a search of a
// non-empty list go through the scan state, which walks the store one entry per cycle,
// as the store has one read port and one write port. The next command can be taken
// at the same edge that ends the result.
// Reset clears the fill count and the sequencer; the store itself is never cleared.
// The result strobe cannot be held off, so the block never waits on its receiver.

module array_list_engine_unit #(
  parameter int DEPTH = alen_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  alen_pkg::alen_item_t  item,
  output logic                  done,
  output alen_pkg::alen_result_t result
);

  // Fill and pointer width holds DEPTH itself; the address width indexes the store.
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (FW > alen_pkg::POS_W) ? FW : alen_pkg::POS_W;

  alen_pkg::alen_state_t   state, state_next;
  alen_pkg::alen_cmd_t     cmd_q, cmd_q_next;
  logic [FW-1:0]           fill, fill_next;
  logic [FW-1:0]           ptr, ptr_next;
  logic [FW-1:0]           lim, lim_next;
  logic [FW-1:0]           ra_q, ra_q_next;
  logic                    rv, rv_next;
  logic                    first, first_next;
  logic [alen_pkg::KEY_W-1:0] key_q, key_q_next;
  logic [alen_pkg::KEY_W-1:0] kout_q, kout_q_next;
  logic                    done_next;
  alen_pkg::alen_result_t  result_next;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [alen_pkg::KEY_W-1:0] mem_wdata;
  logic [alen_pkg::KEY_W-1:0] mem_rdata;
  logic [FW-1:0]           ra_dec;
  logic [CW-1:0]           pos_ext;
  logic [CW-1:0]           fill_ext;

  alen_ram #(
    .WIDTH (alen_pkg::KEY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign busy     = (state != alen_pkg::ST_IDLE);
  assign ra_dec   = ra_q - 1'b1;
  assign pos_ext  = CW'(item.position);
  assign fill_ext = CW'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alen_pkg::ST_IDLE;
      fill  <= '0;
      rv    <= 1'b0;
      first <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      rv    <= rv_next;
      first <= first_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q  <= cmd_q_next;
    ptr    <= ptr_next;
    lim    <= lim_next;
    ra_q   <= ra_q_next;
    key_q  <= key_q_next;
    kout_q <= kout_q_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    cmd_q_next  = cmd_q;
    fill_next   = fill;
    ptr_next    = ptr;
    lim_next    = lim;
    ra_q_next   = ra_q;
    rv_next     = rv;
    first_next  = first;
    key_q_next  = key_q;
    kout_q_next = kout_q;
    done_next   = 1'b0;
    result_next = result;
    mem_we      = 1'b0;
    mem_waddr   = fill[AW-1:0];
    mem_wdata   = item.key;

    case (state)
      alen_pkg::ST_IDLE: begin
        if (start) begin
          cmd_q_next = item.cmd;
          key_q_next = item.key;
          rv_next    = 1'b0;
          first_next = 1'b1;
          case (item.cmd)
            alen_pkg::CMD_APPEND: begin
              done_next           = 1'b1;
              result_next.key_out = '0;
              if (fill != FW'(DEPTH)) begin
                mem_we         = 1'b1;
                fill_next      = fill + 1'b1;
                result_next.ok = 1'b1;
              end else begin
                result_next.ok = 1'b0;
              end
            end
            alen_pkg::CMD_REMOVE, alen_pkg::CMD_READ: begin
              if (pos_ext < fill_ext) begin
                // Scan from the position; a read stops after one entry.
                ptr_next   = FW'(item.position);
                state_next = alen_pkg::ST_SCAN;
                if (item.cmd == alen_pkg::CMD_READ) begin
                  lim_next = FW'(item.position) + 1'b1;
                end else begin
                  lim_next  = fill;
                  fill_next = fill - 1'b1;
                end
              end else begin
                done_next           = 1'b1;
                result_next.ok      = 1'b0;
                result_next.key_out = '0;
              end
            end
            default: begin
              if (fill != '0) begin
                ptr_next   = '0;
                lim_next   = fill;
                state_next = alen_pkg::ST_SCAN;
              end else begin
                done_next           = 1'b1;
                result_next.ok      = 1'b0;
                result_next.key_out = '0;
              end
            end
          endcase
        end
      end

      alen_pkg::ST_SCAN: begin
        // Issue the next read while the previous read's data is consumed.
        if (ptr < lim) begin
          ptr_next  = ptr + 1'b1;
          rv_next   = 1'b1;
          ra_q_next = ptr;
        end else begin
          rv_next = 1'b0;
        end

        if (rv) begin
          first_next = 1'b0;
          if (cmd_q == alen_pkg::CMD_SEARCH) begin
            if (mem_rdata == key_q) begin
              done_next           = 1'b1;
              result_next.ok      = 1'b1;
              result_next.key_out = '0;
              state_next          = alen_pkg::ST_IDLE;
              rv_next             = 1'b0;
            end
          end else if (first) begin
            kout_q_next = mem_rdata;
          end else if (cmd_q == alen_pkg::CMD_REMOVE) begin
            // Move the entry one place down.
            mem_we    = 1'b1;
            mem_waddr = ra_dec[AW-1:0];
            mem_wdata = mem_rdata;
          end
        end else if (ptr >= lim) begin
          done_next  = 1'b1;
          state_next = alen_pkg::ST_IDLE;
          if (cmd_q == alen_pkg::CMD_SEARCH) begin
            result_next.ok      = 1'b0;
            result_next.key_out = '0;
          end else begin
            result_next.ok      = 1'b1;
            result_next.key_out = kout_q;
          end
        end
      end

      default: begin
        state_next = alen_pkg::ST_IDLE;
      end
    endcase

    if (done_next) begin
      result_next.count     = alen_pkg::COUNT_W'(fill_next);
      result_next.empty_res = (fill_next == '0);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill count above the store depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == alen_pkg::ST_IDLE)
    else $error("result strobe while the sequencer is still working");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == alen_pkg::ST_SCAN) |-> (cmd_q == alen_pkg::CMD_REMOVE && !first))
    else $error("store written during a scan that is not a shift");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == alen_pkg::ST_SCAN && rv) |-> ra_q < lim)
    else $error("scan read beyond the end of the list");

  a_append_ok: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == alen_pkg::CMD_APPEND && fill != FW'(DEPTH))
      |=> (done && result.ok))
    else $error("append on a list with room did not succeed");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the array list engine: a directed table followed by
// random append, remove, read and search traffic, checked against an in-bench predictor.
// Depends on alen_pkg and array_list_engine_unit.
`timescale 1ns / 1ps

module tb_top;
  import alen_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  // A shift or a scan walks the store one entry per cycle, so the slowest command
  // walks the whole list. The closing wait covers the slowest command once more.
  localparam int SETTLE_CYC  = LIST_DEPTH + 64;
  localparam int RAND_PHASE  = 360;
  localparam int RAND_TAIL   = 40;
  localparam int MAX_REPORTS = 10;

  // One row of the directed table. Where want_valid is set, the row carries its
  // expected result typed in by hand. Otherwise the predictor supplies it.
  typedef struct {
    alen_item_t   req;
    bit           want_valid;
    alen_result_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  logic         busy;
  alen_item_t   item;
  logic         done;
  alen_result_t result;

  // Predictor state: its own copy of the list and of the fill count.
  logic signed [KEY_W-1:0] list_mem [LIST_DEPTH];
  int                      list_len;
  int                      peak_len;

  // Results still owed by the block, oldest first.
  alen_result_t pending_results [$];
  dir_row_t     dir_rows [$];

  int idle_pct;
  int errors;
  int n_items;
  int n_results;
  int n_ok;
  int n_per_cmd [4];

  array_list_engine_unit #(
    .DEPTH (LIST_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Applies one accepted command to the predictor's list and returns the result
  // that the block ought to give for it.
  function automatic alen_result_t list_apply(alen_item_t req);
    alen_result_t r;
    r = '0;
    case (req.cmd)
      CMD_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          list_mem[list_len] = req.key;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (int'(req.position) < list_len) begin
          r.key_out = list_mem[req.position];
          for (int i = int'(req.position); i < list_len - 1; i++) begin
            list_mem[i] = list_mem[i + 1];
          end
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (int'(req.position) < list_len) begin
          r.key_out = list_mem[req.position];
          r.ok      = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == req.key) begin
            r.ok = 1'b1;
          end
        end
      end
    endcase
    r.count     = COUNT_W'(list_len);
    r.empty_res = (list_len == 0);
    if (list_len > peak_len) begin
      peak_len = list_len;
    end
    return r;
  endfunction

  // Every failure goes through here. Only the first MAX_REPORTS are printed, so
  // that a broken block cannot flood the log.
  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  // Compares one result from the block, field by field, with the oldest expectation.
  function automatic void check_result(alen_result_t got);
    alen_result_t want;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("result with nothing expected: ok=%0b key_out=%0d count=%0d",
                           got.ok, got.key_out, got.count));
      return;
    end
    want = pending_results.pop_front();
    n_results++;
    if (got.ok !== want.ok) begin
      flag_error($sformatf("ok: expected %0b, got %0b", want.ok, got.ok));
    end
    if (got.key_out !== want.key_out) begin
      flag_error($sformatf("key_out: expected %0d, got %0d", want.key_out, got.key_out));
    end
    if (got.count !== want.count) begin
      flag_error($sformatf("count: expected %0d, got %0d", want.count, got.count));
    end
    if (got.empty_res !== want.empty_res) begin
      flag_error($sformatf("empty_res: expected %0b, got %0b", want.empty_res,
                           got.empty_res));
    end
  endfunction

  // Result monitor. The strobe lasts one cycle and cannot be held off, so every
  // cycle with done high ends in exactly one result transfer. The ports are looked
  // at on the falling edge, where they are steady.
  always @(negedge clk) begin
    if (!rst && done) begin
      check_result(result);
    end
  end

  // Leaves the request idle for a random number of cycles, one chance per cycle.
  task automatic sender_gap();
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Presents one command and holds it until the block takes it. The task is entered
  // just after a rising edge and returns at the edge of the transfer. The prediction
  // is made there, so the stimulus generator always sees the list as it now stands.
  task automatic drive_item(input alen_item_t req, input bit want_valid,
                            input alen_result_t want);
    alen_result_t pred;
    bit           taken;
    sender_gap();
    start <= 1'b1;
    item  <= req;
    // Busy only moves at a rising edge, so its mid-cycle value decides the next edge.
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    pred = list_apply(req);
    pending_results.push_back(want_valid ? want : pred);
    n_items++;
    n_per_cmd[req.cmd]++;
    if (pred.ok) begin
      n_ok++;
    end
  endtask

  task automatic drive_checked(input alen_item_t req);
    drive_item(req, 1'b0, '0);
  endtask

  // Holds off new commands until the block has answered everything it was given.
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic alen_item_t make_item(alen_cmd_t cmd, int pos, logic [KEY_W-1:0] key);
    alen_item_t r;
    r.cmd      = cmd;
    r.position = POS_W'(pos);
    r.key      = key;
    return r;
  endfunction

  // Adds one row to the directed table. With want_valid clear, the expected fields
  // are ignored and the predictor decides.
  function automatic void add_row(alen_cmd_t cmd, int pos, logic [KEY_W-1:0] key,
                                 bit want_valid, bit ok, logic [KEY_W-1:0] kout,
                                 int cnt);
    dir_row_t row;
    row.req             = make_item(cmd, pos, key);
    row.want_valid      = want_valid;
    row.want.ok         = ok;
    row.want.key_out    = kout;
    row.want.count      = COUNT_W'(cnt);
    row.want.empty_res  = (cnt == 0);
    dir_rows.push_back(row);
  endfunction

  // Keys are drawn partly from a small pool of corner values, so that duplicates
  // turn up and searches hit; the remainder is fully random across all 32 bits.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return KEY_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // One random command, shaped by the present length of the list. Appends are
  // favoured while the list is short and become rarer as it grows. Positions mostly
  // land inside the list, and the rest are spread over the whole field. Searches
  // look for a key that is held half of the time on a non-empty list.
  function automatic alen_item_t rand_item();
    int        app_pct;
    int        roll;
    int        pos;
    alen_cmd_t cmd;
    logic [KEY_W-1:0] key;
    app_pct = (list_len < 24) ? 45 : ((list_len < 64) ? 30 : 15);
    roll    = $urandom_range(0, 99);
    if (roll < app_pct) begin
      cmd = CMD_APPEND;
    end else if (roll < app_pct + (100 - app_pct) / 3) begin
      cmd = CMD_REMOVE;
    end else if (roll < app_pct + 2 * (100 - app_pct) / 3) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_SEARCH;
    end
    if (list_len > 0 && $urandom_range(0, 99) < 80) begin
      pos = $urandom_range(0, list_len - 1);
    end else begin
      pos = $urandom_range(0, 255);
    end
    if (cmd == CMD_SEARCH && list_len > 0 && $urandom_range(0, 1) == 1) begin
      key = list_mem[$urandom_range(0, list_len - 1)];
    end else begin
      key = pick_key();
    end
    return make_item(cmd, pos, key);
  endfunction

  initial begin
    rst      <= 1'b1;
    start    <= 1'b0;
    item     <= '0;
    list_len  = 0;
    peak_len  = 0;
    idle_pct  = 28;
    errors    = 0;
    n_items   = 0;
    n_results = 0;
    n_ok      = 0;
    n_per_cmd = '{default: 0};

    // Directed table. The list starts empty after reset. Rows with a hand-typed
    // result are the ones that can be read straight off the behaviour: failures on
    // an empty list, appends of the extreme keys, reads and searches, and a remove.
    add_row(CMD_READ,   0,   '0,           1, 0, '0,           0);
    add_row(CMD_REMOVE, 255, '0,           1, 0, '0,           0);
    add_row(CMD_SEARCH, 0,   '0,           1, 0, '0,           0);
    add_row(CMD_APPEND, 0,   32'h7FFF_FFFF, 1, 1, '0,           1);
    add_row(CMD_APPEND, 255, 32'h8000_0000, 1, 1, '0,           2);
    add_row(CMD_APPEND, 0,   '0,           1, 1, '0,           3);
    add_row(CMD_APPEND, 0,   '1,           1, 1, '0,           4);
    add_row(CMD_READ,   0,   '1,           1, 1, 32'h7FFF_FFFF, 4);
    add_row(CMD_READ,   3,   '0,           1, 1, '1,           4);
    // Read one past the end: the position is not below the count.
    add_row(CMD_READ,   4,   '0,           1, 0, '0,           4);
    add_row(CMD_SEARCH, 0,   32'h8000_0000, 1, 1, '0,           4);
    add_row(CMD_SEARCH, 0,   32'd12345,    1, 0, '0,           4);
    // Remove from the middle, after which the later entries have moved down.
    add_row(CMD_REMOVE, 1,   '0,           1, 1, 32'h8000_0000, 3);
    add_row(CMD_READ,   1,   '0,           0, 0, '0,           0);
    add_row(CMD_REMOVE, 2,   '0,           0, 0, '0,           0);
    add_row(CMD_REMOVE, 255, '0,           0, 0, '0,           0);
    // The slot vacated at the top still holds its old key, but must not be found.
    add_row(CMD_SEARCH, 0,   '1,           0, 0, '0,           0);
    add_row(CMD_REMOVE, 0,   '0,           0, 0, '0,           0);
    add_row(CMD_REMOVE, 0,   '0,           0, 0, '0,           0);
    add_row(CMD_SEARCH, 0,   '0,           0, 0, '0,           0);
    add_row(CMD_READ,   128, '0,           0, 0, '0,           0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].req, dir_rows[i].want_valid, dir_rows[i].want);
    end

    // First random phase: the sender is idle a little over a quarter of the time.
    repeat (RAND_PHASE) drive_checked(rand_item());
    wait_all_results();

    // Second random phase: the sender is idle most of the time, so that gaps fall
    // on every stage of a long shift or scan.
    idle_pct = 75;
    repeat (RAND_PHASE) drive_checked(rand_item());
    wait_all_results();

    // Last phase, with no idling: fill the list to the brim, then work its extremes.
    // These are an append to a full list, a read of the top slot, a search for a corner
    // key, a remove at the bottom that shifts the whole list, a remove near the top and
    // a read of the top slot once it lies past the end.
    idle_pct = 0;
    while (list_len < LIST_DEPTH) begin
      drive_checked(make_item(CMD_APPEND, $urandom_range(0, 255), $urandom()));
    end
    drive_checked(make_item(CMD_APPEND, 0, 32'h8000_0000));
    drive_checked(make_item(CMD_READ, 255, '0));
    drive_checked(make_item(CMD_SEARCH, 0, 32'h7FFF_FFFF));
    drive_checked(make_item(CMD_REMOVE, 0, '0));
    drive_checked(make_item(CMD_REMOVE, 254, '0));
    drive_checked(make_item(CMD_READ, 255, '0));
    repeat (RAND_TAIL) drive_checked(rand_item());

    wait_all_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Ran %0d commands (append %0d, remove %0d, read %0d, search %0d), %0d succeeded.",
             n_items, n_per_cmd[CMD_APPEND], n_per_cmd[CMD_REMOVE], n_per_cmd[CMD_READ],
             n_per_cmd[CMD_SEARCH], n_ok);
    $display("Checked %0d results, longest list %0d entries, %0d errors.",
             n_results, peak_len, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is about 1100 commands, each of which may walk
  // the whole list, plus the sender's gaps; 15 ms is several times that.
  initial begin
    #15_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/alen_pkg.sv
rtl/core/alen_ram.sv
rtl/core/array_list_engine_unit.sv
sim/tb_top.sv
